// ===== rtl/two_channel_pid_controller_macros.svh =====
// Assertion macros shared by the controller RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef TWO_CHANNEL_PID_CONTROLLER_MACROS_SVH
`define TWO_CHANNEL_PID_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCPID_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcpid assertion failed");

// Next-cycle implication, checked outside reset.
`define TCPID_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcpid assertion failed");

`endif

// ===== rtl/tcpid_pkg.sv =====
`default_nettype none

package tcpid_pkg;

	localparam int GAIN_W = 16;
	localparam int POS_W = 16;
	localparam int DIFF_W = POS_W + 1;
	localparam int ELIM_W = 18;
	localparam int SUM_W = 32;
	localparam int CFG_DATA_W = 32;
	localparam int DRIVE_W = 32;

	typedef enum logic [2:0] {
		REG_KP_JOINT0 = 3'd0,
		REG_KI_JOINT0 = 3'd1,
		REG_KD_JOINT0 = 3'd2,
		REG_KP_JOINT1 = 3'd3,
		REG_KI_JOINT1 = 3'd4,
		REG_KD_JOINT1 = 3'd5,
		REG_ERROR_LIMIT = 3'd6,
		REG_SUM_LIMIT = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
	} gains_t;

	typedef struct packed {
		gains_t [1:0] gains;
		logic signed [ELIM_W-1:0] error_limit;
		logic signed [SUM_W-1:0] sum_limit;
	} cfg_t;

	typedef struct packed {
		logic joint;
		logic signed [POS_W-1:0] set_point;
		logic signed [POS_W-1:0] measured_position;
	} sample_t;

	// Operands handed from the integrator stage to the multiply stage.
	typedef struct packed {
		logic signed [DIFF_W-1:0] err;
		logic signed [DIFF_W-1:0] vel;
		logic signed [SUM_W-1:0] sum;
		gains_t gains;
	} operands_t;

endpackage

`default_nettype wire

// ===== rtl/tcpid_cfg.sv =====
`default_nettype none

module tcpid_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [tcpid_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output tcpid_pkg::cfg_t cfg
);

	tcpid_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcpid_pkg::REG_KP_JOINT0: cfg_q.gains[0].kp <= cfg_wdata[tcpid_pkg::GAIN_W-1:0];
				tcpid_pkg::REG_KI_JOINT0: cfg_q.gains[0].ki <= cfg_wdata[tcpid_pkg::GAIN_W-1:0];
				tcpid_pkg::REG_KD_JOINT0: cfg_q.gains[0].kd <= cfg_wdata[tcpid_pkg::GAIN_W-1:0];
				tcpid_pkg::REG_KP_JOINT1: cfg_q.gains[1].kp <= cfg_wdata[tcpid_pkg::GAIN_W-1:0];
				tcpid_pkg::REG_KI_JOINT1: cfg_q.gains[1].ki <= cfg_wdata[tcpid_pkg::GAIN_W-1:0];
				tcpid_pkg::REG_KD_JOINT1: cfg_q.gains[1].kd <= cfg_wdata[tcpid_pkg::GAIN_W-1:0];
				tcpid_pkg::REG_ERROR_LIMIT: begin
					cfg_q.error_limit <= cfg_wdata[tcpid_pkg::ELIM_W-1:0];
				end
				tcpid_pkg::REG_SUM_LIMIT: begin
					cfg_q.sum_limit <= cfg_wdata[tcpid_pkg::SUM_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/tcpid_integ.sv =====
`default_nettype none

module tcpid_integ (
	input wire logic clk,
	input wire logic arst_n,
	input tcpid_pkg::cfg_t cfg,
	input tcpid_pkg::sample_t sample_s1,
	input wire logic state_we,
	input wire logic op_load,
	output tcpid_pkg::operands_t op_s2
);

	logic signed [tcpid_pkg::POS_W-1:0] last_pos_q [2];
	logic signed [tcpid_pkg::SUM_W-1:0] error_sum_q [2];

	logic signed [tcpid_pkg::DIFF_W-1:0] err;
	logic signed [tcpid_pkg::DIFF_W-1:0] vel;
	logic signed [tcpid_pkg::SUM_W-1:0] sum_old;
	logic signed [tcpid_pkg::SUM_W:0] sum_try;
	logic signed [tcpid_pkg::SUM_W:0] sum_limit_x;
	logic signed [tcpid_pkg::ELIM_W-1:0] err_x;
	logic signed [tcpid_pkg::SUM_W-1:0] sum_sat;
	logic signed [tcpid_pkg::SUM_W-1:0] sum_new;
	logic accumulate;

	always_comb begin
		sum_old = error_sum_q[sample_s1.joint];
		err = $signed({sample_s1.set_point[tcpid_pkg::POS_W-1], sample_s1.set_point})
			- $signed({sample_s1.measured_position[tcpid_pkg::POS_W-1],
				sample_s1.measured_position});
		vel = $signed({sample_s1.measured_position[tcpid_pkg::POS_W-1],
				sample_s1.measured_position})
			- $signed({last_pos_q[sample_s1.joint][tcpid_pkg::POS_W-1],
				last_pos_q[sample_s1.joint]});
		err_x = $signed({{(tcpid_pkg::ELIM_W - tcpid_pkg::DIFF_W){err[tcpid_pkg::DIFF_W-1]}},
			err});
		sum_try = $signed({{(tcpid_pkg::SUM_W + 1 - tcpid_pkg::DIFF_W){err[tcpid_pkg::DIFF_W-1]}},
			err}) + $signed({sum_old[tcpid_pkg::SUM_W-1], sum_old});
		sum_limit_x = $signed({cfg.sum_limit[tcpid_pkg::SUM_W-1], cfg.sum_limit});
		accumulate = (err_x < cfg.error_limit) && (sum_try < sum_limit_x);
		// Clamp the sum to signed 32 bits when the top two bits disagree.
		if (sum_try[tcpid_pkg::SUM_W] != sum_try[tcpid_pkg::SUM_W-1]) begin
			sum_sat = sum_try[tcpid_pkg::SUM_W]
				? {1'b1, {(tcpid_pkg::SUM_W-1){1'b0}}}
				: {1'b0, {(tcpid_pkg::SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_try[tcpid_pkg::SUM_W-1:0];
		end
		sum_new = accumulate ? sum_sat : sum_old;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q[0] <= '0;
			last_pos_q[1] <= '0;
			error_sum_q[0] <= '0;
			error_sum_q[1] <= '0;
		end else if (state_we) begin
			last_pos_q[sample_s1.joint] <= sample_s1.measured_position;
			error_sum_q[sample_s1.joint] <= sum_new;
		end
	end

	always_ff @(posedge clk) begin
		if (op_load) begin
			op_s2.err <= err;
			op_s2.vel <= vel;
			op_s2.sum <= sum_new;
			op_s2.gains <= cfg.gains[sample_s1.joint];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tcpid_calc.sv =====
`default_nettype none

module tcpid_calc (
	input wire logic clk,
	input tcpid_pkg::operands_t op_s2,
	input wire logic prod_load,
	input wire logic out_load,
	output logic [tcpid_pkg::DRIVE_W-1:0] drive_value_q
);

	localparam int P_W = tcpid_pkg::DIFF_W + tcpid_pkg::GAIN_W;
	localparam int I_W = tcpid_pkg::SUM_W + tcpid_pkg::GAIN_W;
	localparam int TOT_W = I_W + 2;
	localparam int Q_W = TOT_W - 8;

	logic signed [tcpid_pkg::DIFF_W-1:0] err;
	logic signed [tcpid_pkg::DIFF_W-1:0] vel;
	logic signed [tcpid_pkg::SUM_W-1:0] sum;
	logic signed [tcpid_pkg::GAIN_W-1:0] kp;
	logic signed [tcpid_pkg::GAIN_W-1:0] ki;
	logic signed [tcpid_pkg::GAIN_W-1:0] kd;

	logic signed [P_W-1:0] p_term_s3;
	logic signed [P_W-1:0] d_term_s3;
	logic signed [I_W-1:0] i_term_s3;

	logic signed [TOT_W-1:0] total;
	logic signed [TOT_W-1:0] total_adj;
	logic signed [Q_W-1:0] quot;
	logic [tcpid_pkg::DRIVE_W-1:0] drive_sat;

	assign err = op_s2.err;
	assign vel = op_s2.vel;
	assign sum = op_s2.sum;
	assign kp = op_s2.gains.kp;
	assign ki = op_s2.gains.ki;
	assign kd = op_s2.gains.kd;

	always_ff @(posedge clk) begin
		if (prod_load) begin
			p_term_s3 <= err * kp;
			d_term_s3 <= vel * kd;
			i_term_s3 <= sum * ki;
		end
	end

	always_comb begin
		total = $signed({{(TOT_W - P_W){p_term_s3[P_W-1]}}, p_term_s3})
			+ $signed({{(TOT_W - P_W){d_term_s3[P_W-1]}}, d_term_s3})
			+ $signed({{(TOT_W - I_W){i_term_s3[I_W-1]}}, i_term_s3});
		// Divide by 256 rounding toward zero: bias negative values before the shift.
		total_adj = total + $signed({{(TOT_W - 8){1'b0}}, {8{total[TOT_W-1]}}});
		quot = total_adj[TOT_W-1:8];
		if ((&quot[Q_W-1:tcpid_pkg::DRIVE_W-1]) || !(|quot[Q_W-1:tcpid_pkg::DRIVE_W-1])) begin
			drive_sat = quot[tcpid_pkg::DRIVE_W-1:0];
		end else if (quot[Q_W-1]) begin
			drive_sat = {1'b1, {(tcpid_pkg::DRIVE_W-1){1'b0}}};
		end else begin
			drive_sat = {1'b0, {(tcpid_pkg::DRIVE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			drive_value_q <= drive_sat;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/two_channel_pid_controller.sv =====
// Channel   Port group          Contents
// input     s_tvalid/s_tready   tdata: set_point, measured_position; tuser: joint
// output    m_tvalid/m_tready   tdata: drive_value
// config    cfg_we/cfg_index    cfg_wdata, eight registers, write only
//
// One word is accepted per cycle while s_tready is high.
// The pipeline is input register, integrator, multipliers, and output register.
// The integrator updates the per-joint state as a word leaves the input register,
// so words for the same joint may follow each other without gaps.
// Reset clears gains, limits, last positions and error sums.
// On an output stall, empty stages still fill; s_tready falls only when all four are full.
`default_nettype none

`include "two_channel_pid_controller_macros.svh"

module two_channel_pid_controller (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [31:0] s_tdata, // set_point [15:0], measured_position [31:16]
	input wire logic [0:0] s_tuser, // joint [0]
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [31:0] m_tdata, // drive_value [31:0]
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [tcpid_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	tcpid_pkg::cfg_t cfg;
	tcpid_pkg::sample_t sample_s1;
	tcpid_pkg::operands_t op_s2;

	logic in_valid_s1;
	logic op_valid_s2;
	logic prod_valid_s3;
	logic out_valid_q;

	logic in_load;
	logic op_load;
	logic prod_load;
	logic out_load;

	assign out_load = !out_valid_q || m_tready;
	assign prod_load = !prod_valid_s3 || out_load;
	assign op_load = !op_valid_s2 || prod_load;
	assign in_load = !in_valid_s1 || op_load;

	assign s_tready = in_load;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			op_valid_s2 <= 1'b0;
			prod_valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_load) begin
				in_valid_s1 <= s_tvalid;
			end
			if (op_load) begin
				op_valid_s2 <= in_valid_s1;
			end
			if (prod_load) begin
				prod_valid_s3 <= op_valid_s2;
			end
			if (out_load) begin
				out_valid_q <= prod_valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_load) begin
			sample_s1.joint <= s_tuser[0];
			sample_s1.set_point <= s_tdata[15:0];
			sample_s1.measured_position <= s_tdata[31:16];
		end
	end

	tcpid_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	tcpid_integ u_integ (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.sample_s1(sample_s1),
		.state_we(op_load && in_valid_s1),
		.op_load(op_load),
		.op_s2(op_s2)
	);

	tcpid_calc u_calc (
		.clk(clk),
		.op_s2(op_s2),
		.prod_load(prod_load),
		.out_load(out_load),
		.drive_value_q(m_tdata)
	);

	`TCPID_ASSERT_IMP(a_ready_when_out_empty, !out_valid_q, s_tready)
	`TCPID_ASSERT_IMP(a_stall_only_when_full, !s_tready,
		in_valid_s1 && op_valid_s2 && prod_valid_s3 && out_valid_q && !m_tready)
	`TCPID_ASSERT_NXT(a_product_reaches_out, prod_valid_s3 && out_load, out_valid_q)

endmodule

`default_nettype wire
